>>> rtl/bxavg_pkg.sv
// bxavg_pkg: shared widths, register indexes, state codes and structs of the
// box average image downsampler
// no dependencies; used by every module in rtl/ except bxavg_ram
package bxavg_pkg;

	// stream and field widths
	localparam int PIX_W = 32;
	localparam int CH_N  = 4;
	localparam int CH_W  = 8;

	// configuration port
	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 3;
	localparam int WIN_W       = 5;
	localparam int DIM_W       = 13;

	// per-column and horizontal channel sums, wrapping at these widths
	localparam int COL_W = 20;
	localparam int HS_W  = 24;

	// reciprocal of the block area: exact floor division of any HS_W-bit sum
	localparam int AREA_W      = 2 * WIN_W;
	localparam int RECIP_SHIFT = HS_W + AREA_W;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int RECIP_LO_W  = (RECIP_W + 1) / 2;
	localparam int RECIP_HI_W  = RECIP_W - RECIP_LO_W;
	localparam int PROD_W      = HS_W + RECIP_W;
	localparam int STEP_W      = $clog2(RECIP_SHIFT);

	// result queue
	localparam int OQ_DEPTH = 8;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// default parameter values
	localparam int DEF_MAX_WIDTH  = 4096;
	localparam int DEF_MAX_WINDOW = 16;

	// register reset values
	localparam logic [WIN_W-1:0] RST_WINDOW = WIN_W'(2);
	localparam logic [DIM_W-1:0] RST_DIM    = DIM_W'(4096);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_WINDOW_WIDTH  = 3'd0,
		REG_WINDOW_HEIGHT = 3'd1,
		REG_SOURCE_WIDTH  = 3'd2,
		REG_SOURCE_HEIGHT = 3'd3,
		REG_BORDER_ENABLE = 3'd4
	} reg_index_t;

	typedef enum logic [1:0] {
		GEOM_IDLE,
		GEOM_SETUP,
		GEOM_DIV
	} geom_state_t;

	// clamped geometry and derived values, valid while the geometry unit is idle
	typedef struct packed {
		logic [WIN_W-1:0]   ww;
		logic [WIN_W-1:0]   wh;
		logic [DIM_W-1:0]   w;
		logic [DIM_W-1:0]   h;
		logic [DIM_W-1:0]   used_w;
		logic [DIM_W-1:0]   used_h;
		logic [RECIP_W-1:0] recip;
		logic               border;
	} geom_t;

	// one averaged block waiting for output
	typedef struct packed {
		logic [PIX_W-1:0] avg;
		logic             last_block;
		logic             dup;
	} result_t;

endpackage

>>> rtl/bxavg_ram.sv
// bxavg_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
module bxavg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule

>>> rtl/bxavg_geom.sv
// bxavg_geom: configuration registers, clamping, and a shift-subtract unit that
// derives the used image size and the area reciprocal after reset and after every write
// depends on bxavg_pkg
module bxavg_geom #(
	parameter int MAX_WIDTH  = bxavg_pkg::DEF_MAX_WIDTH,
	parameter int MAX_WINDOW = bxavg_pkg::DEF_MAX_WINDOW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bxavg_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [bxavg_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic                                busy,
	output bxavg_pkg::geom_t                    geom
);

	localparam int WIN_W = bxavg_pkg::WIN_W;
	localparam int DIM_W = bxavg_pkg::DIM_W;
	localparam int AREA_W = bxavg_pkg::AREA_W;
	localparam int KS = bxavg_pkg::RECIP_SHIFT;
	localparam int STEP_W = bxavg_pkg::STEP_W;

	logic [WIN_W-1:0] wwr_q, whr_q;
	logic [DIM_W-1:0] wr_q, hr_q;
	logic             brd_q;

	bxavg_pkg::geom_state_t state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	logic [WIN_W-1:0]  ww_q, wh_q, remw_q, remh_q;
	logic [DIM_W-1:0]  w_q, h_q;
	logic [AREA_W-1:0] area_q, rq_q;
	logic [KS-1:0]     wsh_q, hsh_q, quo_q;

	logic [WIN_W-1:0]  ww_c, wh_c, remw_n, remh_n;
	logic [DIM_W-1:0]  w_c, h_c;
	logic [WIN_W:0]    tw, th;
	logic [AREA_W:0]   tr;
	logic [AREA_W-1:0] rq_n;
	logic              qbit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wwr_q <= bxavg_pkg::RST_WINDOW;
			whr_q <= bxavg_pkg::RST_WINDOW;
			wr_q  <= bxavg_pkg::RST_DIM;
			hr_q  <= bxavg_pkg::RST_DIM;
			brd_q <= 1'b0;
		end else if (cfg_we) begin
			case (bxavg_pkg::reg_index_t'(cfg_index))
				bxavg_pkg::REG_WINDOW_WIDTH: begin
					wwr_q <= cfg_data[WIN_W-1:0];
				end
				bxavg_pkg::REG_WINDOW_HEIGHT: begin
					whr_q <= cfg_data[WIN_W-1:0];
				end
				bxavg_pkg::REG_SOURCE_WIDTH: begin
					wr_q <= cfg_data[DIM_W-1:0];
				end
				bxavg_pkg::REG_SOURCE_HEIGHT: begin
					hr_q <= cfg_data[DIM_W-1:0];
				end
				bxavg_pkg::REG_BORDER_ENABLE: begin
					brd_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// clamp to the supported ranges
	always_comb begin
		if (wwr_q == '0) begin
			ww_c = WIN_W'(1);
		end else if (32'(wwr_q) > MAX_WINDOW) begin
			ww_c = WIN_W'(MAX_WINDOW);
		end else begin
			ww_c = wwr_q;
		end
		if (whr_q == '0) begin
			wh_c = WIN_W'(1);
		end else if (32'(whr_q) > MAX_WINDOW) begin
			wh_c = WIN_W'(MAX_WINDOW);
		end else begin
			wh_c = whr_q;
		end
		if (wr_q == '0) begin
			w_c = DIM_W'(1);
		end else if (32'(wr_q) > MAX_WIDTH) begin
			w_c = DIM_W'(MAX_WIDTH);
		end else begin
			w_c = wr_q;
		end
		h_c = (hr_q == '0) ? DIM_W'(1) : hr_q;
	end

	// one restoring step for each of the three divisions
	always_comb begin
		tw = {remw_q, wsh_q[KS-1]};
		th = {remh_q, hsh_q[KS-1]};
		tr = {rq_q, 1'b1};
		remw_n = (tw >= {1'b0, ww_q}) ? WIN_W'(tw - {1'b0, ww_q}) : WIN_W'(tw);
		remh_n = (th >= {1'b0, wh_q}) ? WIN_W'(th - {1'b0, wh_q}) : WIN_W'(th);
		qbit = (tr >= {1'b0, area_q});
		rq_n = qbit ? AREA_W'(tr - {1'b0, area_q}) : AREA_W'(tr);
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bxavg_pkg::GEOM_SETUP;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		case (state_q)
			bxavg_pkg::GEOM_IDLE: begin
				step_d = '0;
			end
			bxavg_pkg::GEOM_SETUP: begin
				state_d = bxavg_pkg::GEOM_DIV;
				step_d  = '0;
			end
			bxavg_pkg::GEOM_DIV: begin
				step_d = step_q + 1'b1;
				if (32'(step_q) == KS - 1) begin
					state_d = bxavg_pkg::GEOM_IDLE;
				end
			end
			default: begin
				state_d = bxavg_pkg::GEOM_SETUP;
			end
		endcase
		if (cfg_we) begin
			state_d = bxavg_pkg::GEOM_SETUP;
		end
	end

	// divider datapath
	always_ff @(posedge clk) begin
		if (state_q == bxavg_pkg::GEOM_SETUP) begin
			ww_q   <= ww_c;
			wh_q   <= wh_c;
			w_q    <= w_c;
			h_q    <= h_c;
			area_q <= {{WIN_W{1'b0}}, ww_c} * {{WIN_W{1'b0}}, wh_c};
			wsh_q  <= KS'(w_c);
			hsh_q  <= KS'(h_c);
			remw_q <= '0;
			remh_q <= '0;
			rq_q   <= '0;
			quo_q  <= '0;
		end else if (state_q == bxavg_pkg::GEOM_DIV) begin
			wsh_q  <= {wsh_q[KS-2:0], 1'b0};
			hsh_q  <= {hsh_q[KS-2:0], 1'b0};
			remw_q <= remw_n;
			remh_q <= remh_n;
			rq_q   <= rq_n;
			quo_q  <= {quo_q[KS-2:0], qbit};
		end
	end

	// derived geometry
	assign busy = (state_q != bxavg_pkg::GEOM_IDLE);

	always_comb begin
		geom.ww     = ww_q;
		geom.wh     = wh_q;
		geom.w      = w_q;
		geom.h      = h_q;
		geom.used_w = w_q - DIM_W'(remw_q);
		geom.used_h = h_q - DIM_W'(remh_q);
		geom.recip  = bxavg_pkg::RECIP_W'(quo_q) + 1'b1;
		geom.border = brd_q;
	end

endmodule

>>> rtl/bxavg_accum.sv
// bxavg_accum: raster position counters, line store read-modify-write of the
// column sums, horizontal running sum and reciprocal-multiply averaging
// depends on bxavg_pkg and bxavg_ram
module bxavg_accum #(
	parameter int MAX_WIDTH = bxavg_pkg::DEF_MAX_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bxavg_pkg::geom_t              geom,
	input  logic                          in_accept,
	input  logic [bxavg_pkg::PIX_W-1:0]   pixel,
	output logic                          push,
	output bxavg_pkg::result_t            push_data,
	output logic [1:0]                    inflight
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WIN_W = bxavg_pkg::WIN_W;
	localparam int DIM_W = bxavg_pkg::DIM_W;
	localparam int CH_N = bxavg_pkg::CH_N;
	localparam int CH_W = bxavg_pkg::CH_W;
	localparam int COL_W = bxavg_pkg::COL_W;
	localparam int HS_W = bxavg_pkg::HS_W;
	localparam int LO_W = bxavg_pkg::RECIP_LO_W;
	localparam int HI_W = bxavg_pkg::RECIP_HI_W;
	localparam int PL_W = HS_W + LO_W;
	localparam int PH_W = HS_W + HI_W;
	localparam int PROD_W = bxavg_pkg::PROD_W;
	localparam int RAM_W = CH_N * COL_W;

	// raster position
	logic [CW-1:0]    col_q;
	logic [DIM_W-1:0] row_q;
	logic [WIN_W-1:0] ox_q, oy_q;

	logic in_region, emit, last_block, col_wrap, row_wrap, ox_wrap, oy_wrap, hit;

	// stage 1: line store data back
	logic                 v_s1, oy0_s1, ox0_s1, emit_s1, lastb_s1, dup_s1, fwd_s1;
	logic [CW-1:0]        addr_s1;
	logic [bxavg_pkg::PIX_W-1:0] pix_s1;
	logic [RAM_W-1:0]     rdata, col_new, fwd_q;
	logic [HS_W-1:0]      hsum_q [CH_N];
	logic [HS_W-1:0]      hsum_n [CH_N];

	// stage 2: multiply
	logic            v_s2, lastb_s2, dup_s2;
	logic [HS_W-1:0] hsum_s2 [CH_N];

	// stage 3: quotient
	logic            v_s3, lastb_s3, dup_s3;
	logic [PL_W-1:0] plo_s3 [CH_N];
	logic [PH_W-1:0] phi_s3 [CH_N];

	// block position decode for the current item
	always_comb begin
		in_region  = (32'(col_q) < 32'(geom.used_w)) && (row_q < geom.used_h);
		ox_wrap    = (32'(ox_q) + 32'd1 >= 32'(geom.ww));
		oy_wrap    = (32'(oy_q) + 32'd1 >= 32'(geom.wh));
		emit       = ox_wrap && oy_wrap;
		last_block = (32'(col_q) + 32'(geom.ww) >= 32'(geom.used_w));
		col_wrap   = (32'(col_q) + 32'd1 >= 32'(geom.w));
		row_wrap   = (32'(row_q) + 32'd1 >= 32'(geom.h));
		hit        = v_s1 && (addr_s1 == col_q);
	end

	// position counters advance on every accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ox_q  <= '0;
			oy_q  <= '0;
		end else if (in_accept) begin
			if (col_wrap) begin
				col_q <= '0;
				ox_q  <= '0;
				if (row_wrap) begin
					row_q <= '0;
					oy_q  <= '0;
				end else begin
					row_q <= row_q + 1'b1;
					oy_q  <= oy_wrap ? '0 : oy_q + 1'b1;
				end
			end else begin
				col_q <= col_q + 1'b1;
				ox_q  <= ox_wrap ? '0 : ox_q + 1'b1;
			end
		end
	end

	// line store of per-column channel sums
	bxavg_ram #(
		.WIDTH(RAM_W),
		.DEPTH(MAX_WIDTH)
	) u_line (
		.clk  (clk),
		.we   (v_s1),
		.waddr(addr_s1),
		.wdata(col_new),
		.raddr(col_q),
		.rdata(rdata)
	);

	// pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_accept && in_region;
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1 payload, with a forward flag when the previous item writes the same column
	always_ff @(posedge clk) begin
		addr_s1  <= col_q;
		pix_s1   <= pixel;
		oy0_s1   <= (oy_q == '0);
		ox0_s1   <= (ox_q == '0);
		emit_s1  <= emit;
		lastb_s1 <= last_block;
		dup_s1   <= last_block && geom.border;
		fwd_s1   <= hit;
		fwd_q    <= col_new;
	end

	// column and horizontal sum update
	always_comb begin
		logic [COL_W-1:0] old_sum;
		logic [COL_W-1:0] ch;
		logic [COL_W-1:0] new_sum;
		for (int c = 0; c < CH_N; c++) begin
			old_sum = fwd_s1 ? fwd_q[c*COL_W +: COL_W] : rdata[c*COL_W +: COL_W];
			ch      = COL_W'(pix_s1[c*CH_W +: CH_W]);
			new_sum = oy0_s1 ? ch : old_sum + ch;
			col_new[c*COL_W +: COL_W] = new_sum;
			hsum_n[c] = ox0_s1 ? HS_W'(new_sum) : hsum_q[c] + HS_W'(new_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CH_N; c++) begin
				hsum_q[c] <= '0;
			end
		end else if (v_s1) begin
			for (int c = 0; c < CH_N; c++) begin
				hsum_q[c] <= hsum_n[c];
			end
		end
	end

	// stage 2 and 3 registers: sum times reciprocal in two partial products
	always_ff @(posedge clk) begin
		lastb_s2 <= lastb_s1;
		dup_s2   <= dup_s1;
		lastb_s3 <= lastb_s2;
		dup_s3   <= dup_s2;
		for (int c = 0; c < CH_N; c++) begin
			hsum_s2[c] <= hsum_n[c];
			plo_s3[c]  <= PL_W'(hsum_s2[c]) * PL_W'(geom.recip[LO_W-1:0]);
			phi_s3[c]  <= PH_W'(hsum_s2[c]) * PH_W'(geom.recip[LO_W +: HI_W]);
		end
	end

	// quotient low byte per channel
	always_comb begin
		logic [PROD_W-1:0] prod;
		push_data.last_block = lastb_s3;
		push_data.dup        = dup_s3;
		for (int c = 0; c < CH_N; c++) begin
			prod = (PROD_W'(phi_s3[c]) << LO_W) + PROD_W'(plo_s3[c]);
			push_data.avg[c*CH_W +: CH_W] = prod[bxavg_pkg::RECIP_SHIFT +: CH_W];
		end
	end

	assign push     = v_s3;
	assign inflight = {1'b0, v_s1} + {1'b0, v_s2} + {1'b0, v_s3};

endmodule

>>> rtl/bxavg_outq.sv
// bxavg_outq: queue of averaged blocks and the output stream, which sends a
// second border copy for blocks that close a row with the border on
// depends on bxavg_pkg
module bxavg_outq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  bxavg_pkg::result_t            push_data,
	output logic [bxavg_pkg::OQ_CW-1:0]   count,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [bxavg_pkg::PIX_W-1:0]   m_axis_tdata,
	output logic [1:0]                    m_axis_tuser,
	output logic                          m_axis_tlast
);

	localparam int AW = bxavg_pkg::OQ_AW;

	bxavg_pkg::result_t mem_q [bxavg_pkg::OQ_DEPTH];
	bxavg_pkg::result_t head;
	logic [AW-1:0] wp_q, rp_q;
	logic [bxavg_pkg::OQ_CW-1:0] cnt_q;
	logic phase_q, take, pop;

	assign head          = mem_q[rp_q];
	assign count         = cnt_q;
	assign m_axis_tvalid = (cnt_q != '0);
	assign m_axis_tdata  = head.avg;
	assign m_axis_tuser  = {head.dup ? phase_q : head.last_block, phase_q};
	assign m_axis_tlast  = head.dup ? phase_q : 1'b1;
	assign take          = m_axis_tvalid && m_axis_tready;
	assign pop           = take && (!head.dup || phase_q);

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_data;
		end
	end

	// pointers, fill count and border phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			cnt_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
				end
			endcase
			if (take) begin
				phase_q <= head.dup && !phase_q;
			end
		end
	end

endmodule

>>> rtl/box_average_image_downsample_core.sv
// box_average_image_downsample_core: top level of the RGBA8888 box average
// downsampler; depends on bxavg_pkg, bxavg_geom, bxavg_accum, bxavg_outq
//
//  channel   signals                             moves
//  s_axis    tvalid tready tdata[31:0]           one source pixel per item
//  m_axis    tvalid tready tdata tuser tlast     one averaged pixel per item
//  cfg       cfg_we cfg_index cfg_data           register write, no read-back
//
// one source item per clock when results drain; the item that closes a block
// sends its result through the accumulation pipeline stages and the result
// queue, and a row-closing block with the border on yields two output items
// after reset and after every register write the geometry unit runs its setup
// and shift-subtract steps; s_axis_tready is low meanwhile
// input stalls when the result queue plus items in the pipeline reach OQ_DEPTH
module box_average_image_downsample_core #(
	parameter int MAX_WIDTH  = bxavg_pkg::DEF_MAX_WIDTH,
	parameter int MAX_WINDOW = bxavg_pkg::DEF_MAX_WINDOW
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [bxavg_pkg::PIX_W-1:0]       s_axis_tdata,  // source_pixel
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [bxavg_pkg::PIX_W-1:0]       m_axis_tdata,  // average_pixel
	output logic [1:0]                        m_axis_tuser,  // border_copy, row_end
	output logic                              m_axis_tlast,  // last_of_run
	input  logic                              cfg_we,
	input  logic [bxavg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bxavg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	bxavg_pkg::geom_t   geom;
	bxavg_pkg::result_t oq_data;
	logic               busy, in_accept, oq_push;
	logic [1:0]         inflight;
	logic [bxavg_pkg::OQ_CW-1:0] oq_count;

	// geometry and configuration
	bxavg_geom #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_WINDOW(MAX_WINDOW)
	) u_geom (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.busy     (busy),
		.geom     (geom)
	);

	// credit check against the result queue
	assign s_axis_tready = !busy
		&& ((32'(oq_count) + 32'(inflight)) < bxavg_pkg::OQ_DEPTH);
	assign in_accept = s_axis_tvalid && s_axis_tready;

	// accumulation pipeline
	bxavg_accum #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.geom     (geom),
		.in_accept(in_accept),
		.pixel    (s_axis_tdata),
		.push     (oq_push),
		.push_data(oq_data),
		.inflight (inflight)
	);

	// result queue and output stream
	bxavg_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (oq_push),
		.push_data    (oq_data),
		.count        (oq_count),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	// queue never takes a block when full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		oq_push |-> (32'(oq_count) < bxavg_pkg::OQ_DEPTH))
		else $error("result queue overflow");

	// a result that is not last of its run is followed by its border copy
	a_border_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tlast)
		|=> (m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1]))
		else $error("border copy missing");

	// a register write always restarts the geometry unit
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (busy && !s_axis_tready))
		else $error("geometry not recomputed after write");

endmodule

>>> bench/downsample_checker.sv
// downsample_checker: watches the source, result and register channels of the box
// average downsampler, predicts every averaged pixel and compares it on arrival
// depends on bxavg_pkg
module downsample_checker
	import bxavg_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [PIX_W-1:0]       s_axis_tdata,  // source_pixel
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [PIX_W-1:0]       m_axis_tdata,  // average_pixel
	input  logic [1:0]             m_axis_tuser,  // border_copy, row_end
	input  logic                   m_axis_tlast,  // last_of_run
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     mismatch_count,
	output int                     results_due
);

	typedef struct packed {
		logic [PIX_W-1:0] avg;
		logic             border_copy;
		logic             row_end;
		logic             last_of_run;
	} avg_pixel_t;

	// register copies
	logic [WIN_W-1:0] win_w_reg;
	logic [WIN_W-1:0] win_h_reg;
	logic [DIM_W-1:0] src_w_reg;
	logic [DIM_W-1:0] src_h_reg;
	logic             border_reg;

	// line store, running row sum and raster position
	logic [COL_W-1:0] column_sum [MAX_WIDTH][CH_N];
	logic [HS_W-1:0]  row_sum [CH_N];
	int unsigned      column;
	int unsigned      row;
	int unsigned      win_x;
	int unsigned      win_y;

	avg_pixel_t averages_due [$];

	function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// accumulate one source pixel and queue the averages it closes
	task automatic downsample_pixel(input logic [PIX_W-1:0] px);
		int unsigned ww, wh, w, h, used_w, used_h, area;
		logic [CH_W-1:0]  chan;
		logic [PIX_W-1:0] avg;
		bit               last_block;
		ww = clamp_to(win_w_reg, 1, MAX_WINDOW);
		wh = clamp_to(win_h_reg, 1, MAX_WINDOW);
		w = clamp_to(src_w_reg, 1, MAX_WIDTH);
		h = clamp_to(src_h_reg, 1, 8191);
		used_w = (w / ww) * ww;
		used_h = (h / wh) * wh;
		if (column < used_w && row < used_h) begin
			for (int c = 0; c < CH_N; c++) begin
				chan = px[CH_W*c +: CH_W];
				column_sum[column][c] = (win_y == 0) ? COL_W'(chan)
						: column_sum[column][c] + COL_W'(chan);
				row_sum[c] = (win_x == 0) ? HS_W'(column_sum[column][c])
						: row_sum[c] + HS_W'(column_sum[column][c]);
			end
			// block closes on its bottom right pixel
			if (win_y >= wh - 1 && win_x >= ww - 1) begin
				area = ww * wh;
				for (int c = 0; c < CH_N; c++)
					avg[CH_W*c +: CH_W] = CH_W'(row_sum[c] / area);
				last_block = (column + ww >= used_w);
				if (last_block && border_reg) begin
					averages_due.push_back('{avg, 1'b0, 1'b0, 1'b0});
					averages_due.push_back('{avg, 1'b1, 1'b1, 1'b1});
				end else begin
					averages_due.push_back('{avg, 1'b0, last_block, 1'b1});
				end
			end
		end
		// raster advance, wrapping at the frame end
		if (column >= w - 1) begin
			column = 0;
			win_x = 0;
			if (row >= h - 1) begin
				row = 0;
				win_y = 0;
			end else begin
				row++;
				win_y = (win_y >= wh - 1) ? 0 : win_y + 1;
			end
		end else begin
			column++;
			win_x = (win_x >= ww - 1) ? 0 : win_x + 1;
		end
	endtask

	// register writes, result checks and prediction, one clock at a time
	always @(posedge clk or negedge arst_n) begin
		avg_pixel_t want, got;
		if (!arst_n) begin
			win_w_reg = RST_WINDOW;
			win_h_reg = RST_WINDOW;
			src_w_reg = RST_DIM;
			src_h_reg = RST_DIM;
			border_reg = 1'b0;
			for (int c = 0; c < CH_N; c++)
				row_sum[c] = '0;
			column = 0;
			row = 0;
			win_x = 0;
			win_y = 0;
			averages_due.delete();
			mismatch_count = 0;
			results_due <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_WINDOW_WIDTH:  win_w_reg = cfg_data[WIN_W-1:0];
					REG_WINDOW_HEIGHT: win_h_reg = cfg_data[WIN_W-1:0];
					REG_SOURCE_WIDTH:  src_w_reg = cfg_data[DIM_W-1:0];
					REG_SOURCE_HEIGHT: src_h_reg = cfg_data[DIM_W-1:0];
					REG_BORDER_ENABLE: border_reg = cfg_data[0];
					default: ;
				endcase
			end
			// compare each result item with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tlast};
				if (averages_due.size() == 0) begin
					if (mismatch_count < 10)
						$display("unexpected result: avg %h border %b row_end %b last %b",
								got.avg, got.border_copy, got.row_end, got.last_of_run);
					mismatch_count++;
				end else begin
					want = averages_due.pop_front();
					if (got != want) begin
						if (mismatch_count < 10)
							$display("mismatch: expected avg %h border %b row_end %b last %b,",
									want.avg, want.border_copy, want.row_end,
									want.last_of_run,
									" got avg %h border %b row_end %b last %b",
									got.avg, got.border_copy, got.row_end, got.last_of_run);
						mismatch_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				downsample_pixel(s_axis_tdata);
			results_due <= averages_due.size();
		end
	end

endmodule

>>> bench/tb.sv
// tb: stimulus and verdict for box_average_image_downsample_core; drives pixel
// frames under many window and image settings, downsample_checker does the checking
// depends on bxavg_pkg, downsample_checker and the rtl
module tb;
	import bxavg_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int RANDOM_PIXELS  = 1200;
	localparam int WIDE_PIXELS    = 256;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [PIX_W-1:0]       s_axis_tdata;   // source_pixel
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [PIX_W-1:0]       m_axis_tdata;   // average_pixel
	logic [1:0]             m_axis_tuser;   // border_copy, row_end
	logic                   m_axis_tlast;   // last_of_run
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int          mismatch_count;
	int          results_due;
	int          idle_cycles = 0;
	int unsigned pixels_sent = 0;
	int unsigned frame_row = 0;   // source row at a setting change, column is always 0
	bit          src_burst = 1'b0;
	bit          sink_burst = 1'b0;
	int          sink_stall = 0;
	int          sink_pick;

	box_average_image_downsample_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	downsample_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.results_due(results_due)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result sink: random stalls, a few long ones, and stretches always ready
	always @(negedge clk) begin
		if ($urandom_range(0, 149) == 0)
			sink_burst = !sink_burst;
		if (sink_stall > 0) begin
			sink_stall--;
			m_axis_tready <= 1'b0;
		end else if (sink_burst) begin
			m_axis_tready <= 1'b1;
		end else begin
			sink_pick = $urandom_range(0, 99);
			if (sink_pick < 65)
				m_axis_tready <= 1'b1;
			else if (sink_pick < 95)
				m_axis_tready <= 1'b0;
			else begin
				sink_stall = $urandom_range(5, 40);
				m_axis_tready <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no item moving on either stream
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("box_average_image_downsample_core test failed");
			$finish;
		end
	end

	function automatic logic [PIX_W-1:0] pick_pixel();
		logic [PIX_W-1:0] px;
		case ($urandom_range(0, 7))
			0: px = '1;
			1: px = '0;
			2: begin
				for (int c = 0; c < CH_N; c++)
					px[CH_W*c +: CH_W] = $urandom_range(0, 1) ? 8'hff : 8'h00;
			end
			default: px = $urandom();
		endcase
		return px;
	endfunction

	// mostly small windows, sometimes sizes that clamp
	function automatic int unsigned pick_window();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? 0 : $urandom_range(DEF_MAX_WINDOW + 1, 31);
		return $urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, DEF_MAX_WINDOW);
	endfunction

	task automatic send_pixel(input logic [PIX_W-1:0] px);
		int gap;
		int pick;
		if ($urandom_range(0, 99) == 0)
			src_burst = !src_burst;
		gap = 0;
		if (!src_burst) begin
			pick = $urandom_range(0, 99);
			if (pick >= 90)
				gap = $urandom_range(5, 40);
			else if (pick >= 60)
				gap = $urandom_range(1, 3);
		end
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= px;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		pixels_sent++;
	endtask

	task automatic write_reg(input reg_index_t idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
	endtask

	task automatic wait_drained();
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// new setting once idle, then pixels up to a frame end or a block row boundary
	task automatic run_setting(input int unsigned ww_raw, input int unsigned wh_raw,
			input int unsigned w_raw, input int unsigned h_raw, input bit border,
			input int unsigned extra_frames, input bit partial);
		int unsigned cwh, cw, ch, rows, k;
		wait_drained();
		write_reg(REG_WINDOW_WIDTH, ww_raw);
		write_reg(REG_WINDOW_HEIGHT, wh_raw);
		write_reg(REG_SOURCE_WIDTH, w_raw);
		write_reg(REG_SOURCE_HEIGHT, h_raw);
		write_reg(REG_BORDER_ENABLE, border);
		@(negedge clk);
		cfg_we <= 1'b0;
		cwh = (wh_raw == 0) ? 1 : ((wh_raw > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : wh_raw);
		cw = (w_raw == 0) ? 1 : ((w_raw > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w_raw);
		ch = (h_raw == 0) ? 1 : h_raw;
		// a row past the new height wraps at its end, otherwise finish the frame
		rows = (frame_row >= ch) ? 1 : ch - frame_row;
		rows += extra_frames * ch;
		frame_row = 0;
		if (partial && ch > cwh) begin
			k = $urandom_range(1, (ch - 1) / cwh);
			rows += k * cwh;
			frame_row = k * cwh;
		end
		repeat (cw * rows) send_pixel(pick_pixel());
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
	endtask

	initial begin
		int unsigned random_base;
		int unsigned ww_raw, wh_raw, cww, cwh, w_raw, h_raw, frames;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_WINDOW_WIDTH;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset window and border, one 2x2 image of saturated and small pixels
		write_reg(REG_SOURCE_WIDTH, 2);
		write_reg(REG_SOURCE_HEIGHT, 2);
		@(negedge clk);
		cfg_we <= 1'b0;
		send_pixel(32'hffffffff);
		send_pixel(32'h01010101);
		send_pixel(32'hfefefefe);
		send_pixel(32'hffffffff);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		// unit window pass-through with border copies
		run_setting(1, 1, 2, 1, 1'b1, 0, 1'b0);
		// oversized width clamps to 16, zero height acts as 1, leftover column dropped
		run_setting(31, 0, 17, 1, 1'b1, 0, 1'b0);
		// image smaller than the window
		run_setting(4, 2, 3, 0, 1'b1, 0, 1'b0);
		// zero width acts as 1, leave the frame at a block row boundary
		run_setting(0, 2, 0, 3, 1'b1, 0, 1'b1);
		// setting changed mid-frame with the row past the new height
		run_setting(3, 2, 3, 2, 1'b0, 1, 1'b0);
		// largest window
		run_setting(16, 16, 16, 16, 1'b0, 0, 1'b0);

		// random settings, mostly images that hold several blocks
		random_base = pixels_sent;
		while (pixels_sent - random_base < RANDOM_PIXELS) begin
			ww_raw = pick_window();
			wh_raw = pick_window();
			cww = (ww_raw == 0) ? 1 : ((ww_raw > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : ww_raw);
			cwh = (wh_raw == 0) ? 1 : ((wh_raw > DEF_MAX_WINDOW) ? DEF_MAX_WINDOW : wh_raw);
			if ($urandom_range(0, 9) == 0) begin
				w_raw = $urandom_range(0, cww);
				h_raw = $urandom_range(0, cwh);
			end else begin
				w_raw = cww * $urandom_range(1, 3) + $urandom_range(0, cww - 1);
				h_raw = cwh * $urandom_range(1, 3) + $urandom_range(0, cwh - 1);
				if (w_raw * h_raw > 640) begin
					h_raw = cwh;
					w_raw = cww * $urandom_range(1, 2);
				end
			end
			frames = (w_raw * h_raw <= 120) ? $urandom_range(0, 2) : 0;
			run_setting(ww_raw, wh_raw, w_raw, h_raw, $urandom_range(0, 1), frames,
					$urandom_range(0, 1));
		end

		// widest line clamped from above; the run ends part way along that row, and
		// the height reaches the current row so the row lies inside the image
		wait_drained();
		write_reg(REG_WINDOW_WIDTH, DEF_MAX_WINDOW);
		write_reg(REG_WINDOW_HEIGHT, 1);
		write_reg(REG_SOURCE_WIDTH, 8191);
		write_reg(REG_SOURCE_HEIGHT, frame_row + 1);
		write_reg(REG_BORDER_ENABLE, 1);
		@(negedge clk);
		cfg_we <= 1'b0;
		repeat (WIDE_PIXELS) send_pixel(pick_pixel());
		@(negedge clk);
		s_axis_tvalid <= 1'b0;

		wait_drained();
		if (mismatch_count == 0)
			$display("box_average_image_downsample_core test passed");
		else
			$display("box_average_image_downsample_core test failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/bxavg_pkg.sv
rtl/bxavg_ram.sv
rtl/bxavg_geom.sv
rtl/bxavg_accum.sv
rtl/bxavg_outq.sv
rtl/box_average_image_downsample_core.sv
bench/downsample_checker.sv
bench/tb.sv
